// ===== src/cascading_prescaled_timer_bank_defines.svh =====
// assertion macros for the timer bank
`ifndef CASCADING_PRESCALED_TIMER_BANK_DEFINES_SVH
`define CASCADING_PRESCALED_TIMER_BANK_DEFINES_SVH

// check that is skipped while reset is held
`define CPTB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds at every edge, reset included
`define CPTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cptb_pkg.sv =====
// shared constants, types and helpers of the timer bank
`timescale 1ns / 1ps

package cptb_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int COUNT_WIDTH = 16;

  localparam int IDX_W      = 2;
  localparam int NUM_CTRL   = 4;
  localparam int RELOAD_W   = 16;
  localparam int PRE_W      = 10;
  localparam int OUT_W      = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register map of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_BASE = 3'd4;

  // prescale select codes
  localparam logic [1:0] PRESC_DIV1    = 2'd0;
  localparam logic [1:0] PRESC_DIV64   = 2'd1;
  localparam logic [1:0] PRESC_DIV256  = 2'd2;
  localparam logic [1:0] PRESC_DIV1024 = 2'd3;

  // control register layout, msb first
  typedef struct packed {
    logic       irq_en;
    logic       cascade;
    logic [1:0] presc_sel;
  } ctl_t;

  // per-cell status handed to the top level
  typedef struct packed {
    logic wrap;
    logic irq;
  } cell_stat_t;

  // prescaler terminal count for a select code
  function automatic logic [PRE_W:0] presc_limit(input logic [1:0] sel);
    logic [PRE_W:0] lim;
    case (sel)
      PRESC_DIV64:   lim = (PRE_W+1)'(64);
      PRESC_DIV256:  lim = (PRE_W+1)'(256);
      PRESC_DIV1024: lim = (PRE_W+1)'(1024);
      default:       lim = (PRE_W+1)'(1);
    endcase
    return lim;
  endfunction

  // reload register to counter width
  function automatic logic [COUNT_WIDTH-1:0] reload_to_cnt(input logic [RELOAD_W-1:0] rl);
    logic [COUNT_WIDTH+RELOAD_W-1:0] tmp;
    tmp = {{COUNT_WIDTH{1'b0}}, rl};
    return tmp[COUNT_WIDTH-1:0];
  endfunction

  // counter to result width
  function automatic logic [OUT_W-1:0] cnt_to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_W-1:0] tmp;
    tmp = {{OUT_W{1'b0}}, c};
    return tmp[OUT_W-1:0];
  endfunction

endpackage

// ===== src/cptb_cell.sv =====
// one timer: prescaler, counter and reload, with carry to the next cell
`timescale 1ns / 1ps

module cptb_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cptb_pkg::ctl_t                       ctl,
  input  logic [cptb_pkg::RELOAD_W-1:0]        reload,
  input  logic                                 tick_direct,
  input  logic                                 carry_in,
  output cptb_pkg::cell_stat_t                 stat,
  output logic [cptb_pkg::COUNT_WIDTH-1:0]     count_nxt
);

  logic [cptb_pkg::COUNT_WIDTH-1:0] cnt_r;
  logic [cptb_pkg::PRE_W-1:0]       pre_r;
  logic [cptb_pkg::PRE_W-1:0]       pre_nxt;
  logic [cptb_pkg::PRE_W:0]         pre_inc;
  logic                             fire;
  logic                             bump;
  logic                             wrap;

  // prescaler: divides direct ticks, select zero passes every tick
  always_comb begin
    pre_inc = {1'b0, pre_r} + (cptb_pkg::PRE_W+1)'(1);
    pre_nxt = pre_r;
    fire    = tick_direct;
    if (tick_direct && (ctl.presc_sel != cptb_pkg::PRESC_DIV1)) begin
      if (pre_inc >= cptb_pkg::presc_limit(ctl.presc_sel)) begin
        pre_nxt = '0;
      end else begin
        pre_nxt = pre_inc[cptb_pkg::PRE_W-1:0];
        fire    = 1'b0;
      end
    end
  end

  // counter: wraps from all ones into the reload value
  always_comb begin
    bump      = fire || carry_in;
    wrap      = bump && (cnt_r == {cptb_pkg::COUNT_WIDTH{1'b1}});
    count_nxt = cnt_r;
    if (wrap) begin
      count_nxt = cptb_pkg::reload_to_cnt(reload);
    end else if (bump) begin
      count_nxt = cnt_r + cptb_pkg::COUNT_WIDTH'(1);
    end
    stat.wrap = wrap;
    stat.irq  = wrap && ctl.irq_en;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pre_r <= '0;
    end else begin
      cnt_r <= count_nxt;
      pre_r <= pre_nxt;
    end
  end

endmodule

// ===== src/cascading_prescaled_timer_bank.sv =====
// Timer bank: one tick per transfer, result registered in the cycle after the tick is taken.
// Throughput: one tick per cycle; the cascade ripples through the row of timer
// cells inside that cycle, so the cell row length sets the critical path.
// A stalled result holds off the input; a result leaving lets the next tick in.
// Synchronous active-low reset clears counters, prescalers, control and reload.
`timescale 1ns / 1ps
`include "cascading_prescaled_timer_bank_defines.svh"

module cascading_prescaled_timer_bank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cptb_pkg::IDX_W-1:0]          in_timer_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cptb_pkg::MASK_W-1:0]         out_irq_raised,
  output logic [cptb_pkg::MASK_W-1:0]         out_overflow_mask,
  output logic [cptb_pkg::OUT_W-1:0]          out_count_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cptb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cptb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cptb_pkg::ctl_t                    ctl_r    [cptb_pkg::NUM_CTRL];
  logic [cptb_pkg::RELOAD_W-1:0]     reload_r [cptb_pkg::NUM_CTRL];
  cptb_pkg::cell_stat_t              stat     [cptb_pkg::NUM_TIMERS];
  logic [cptb_pkg::COUNT_WIDTH-1:0]  cnt_nxt  [cptb_pkg::NUM_TIMERS];
  logic [cptb_pkg::NUM_TIMERS-1:0]   direct;
  logic [cptb_pkg::NUM_TIMERS-1:0]   carry;

  logic                              in_acc;
  logic                              out_acc;
  logic                              out_valid_r;
  logic [cptb_pkg::MASK_W-1:0]       irq_r;
  logic [cptb_pkg::MASK_W-1:0]       ovf_r;
  logic [cptb_pkg::OUT_W-1:0]        cnt_r;
  logic [cptb_pkg::MASK_W-1:0]       irq_nxt;
  logic [cptb_pkg::MASK_W-1:0]       ovf_nxt;
  logic [cptb_pkg::OUT_W-1:0]        cnt_sel_nxt;

  // handshakes
  assign cfg_ready = 1'b1;
  assign out_acc   = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cptb_pkg::NUM_CTRL; i++) begin
        ctl_r[i]    <= '0;
        reload_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < cptb_pkg::NUM_CTRL; i++) begin
        if (cfg_index == cptb_pkg::REG_CTRL_BASE + cptb_pkg::CFG_IDX_W'(i)) begin
          ctl_r[i] <= cptb_pkg::ctl_t'(cfg_data[3:0]);
        end
        if (cfg_index == cptb_pkg::REG_RELOAD_BASE + cptb_pkg::CFG_IDX_W'(i)) begin
          reload_r[i] <= cfg_data[cptb_pkg::RELOAD_W-1:0];
        end
      end
    end
  end

  // row of timer cells, wrap carries into the next cascaded timer
  for (genvar g = 0; g < cptb_pkg::NUM_TIMERS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign direct[g] = in_acc && (in_timer_index == cptb_pkg::IDX_W'(g));
      assign carry[g]  = 1'b0;
    end else begin : g_rest
      assign direct[g] = in_acc && (in_timer_index == cptb_pkg::IDX_W'(g)) &&
                         !ctl_r[g].cascade;
      assign carry[g]  = stat[g-1].wrap && ctl_r[g].cascade;
    end

    cptb_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl_r[g]),
      .reload      (reload_r[g]),
      .tick_direct (direct[g]),
      .carry_in    (carry[g]),
      .stat        (stat[g]),
      .count_nxt   (cnt_nxt[g])
    );
  end

  // collect flags and pick the addressed counter
  always_comb begin
    irq_nxt     = '0;
    ovf_nxt     = '0;
    cnt_sel_nxt = '0;
    for (int i = 0; i < cptb_pkg::NUM_TIMERS; i++) begin
      irq_nxt[i] = stat[i].irq;
      ovf_nxt[i] = stat[i].wrap;
      if (in_timer_index == cptb_pkg::IDX_W'(i)) begin
        cnt_sel_nxt = cptb_pkg::cnt_to_out(cnt_nxt[i]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      irq_r <= irq_nxt;
      ovf_r <= ovf_nxt;
      cnt_r <= cnt_sel_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_irq_raised    = irq_r;
  assign out_overflow_mask = ovf_r;
  assign out_count_value   = cnt_r;

  // checks
  `CPTB_ASSERT_RST(a_irq_needs_wrap, clk, rst_n, out_valid_r |-> ((irq_r & ~ovf_r) == '0), "irq without overflow")
  `CPTB_ASSERT_RST(a_accept_gives_result, clk, rst_n, in_acc |=> out_valid_r, "accepted tick lost its result")
  `CPTB_ASSERT_RST(a_result_drains, clk, rst_n, (out_acc && !in_acc) |=> !out_valid_r, "result repeated")
  `CPTB_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_valid_r, "result valid after reset")

endmodule
